### rtl/core/sas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_pkg
// Shared constants, codes and types of the selective ack scoreboard.
// ----------------------------------------------------------------------------
package sas_pkg;

    // Sizing
    localparam int MAX_PACKETS = 4096;
    localparam int MAX_SCAN    = 64;
    localparam int IDX_W       = $clog2(MAX_PACKETS);   // packet index width
    localparam int CNT_W       = IDX_W + 1;             // holds MAX_PACKETS itself
    localparam int WIN_W       = $clog2(MAX_SCAN) + 1;  // scan window width

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = CNT_W;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'd1;

    localparam logic [CNT_W-1:0] TOTAL_RST  = CNT_W'(1);
    localparam logic [WIN_W-1:0] WINDOW_RST = WIN_W'(MAX_SCAN);

    // Command codes
    localparam logic CMD_ACK  = 1'b0;
    localparam logic CMD_SCAN = 1'b1;

    // Bitmap access request
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } t_bm_req;

endpackage

### rtl/core/sas_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_in_if
// Command channel: ack reports and transmit scan requests.
// ----------------------------------------------------------------------------
interface sas_in_if;
    import sas_pkg::*;

    logic             valid;
    logic             ready;
    logic             command;
    logic [CNT_W-1:0] cumulative_seq;
    logic [IDX_W-1:0] selective_index;

    modport source (output valid, output command, output cumulative_seq,
                    output selective_index, input ready);
    modport sink   (input valid, input command, input cumulative_seq,
                    input selective_index, output ready);
endinterface

### rtl/core/sas_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_out_if
// Result channel: packet indices to send and completion status.
// ----------------------------------------------------------------------------
interface sas_out_if;
    import sas_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] packet_index;
    logic             send_valid;
    logic             last_of_run;
    logic             transfer_complete;

    modport source (output valid, output packet_index, output send_valid,
                    output last_of_run, output transfer_complete, input ready);
    modport sink   (input valid, input packet_index, input send_valid,
                    input last_of_run, input transfer_complete, output ready);
endinterface

### rtl/core/sas_bitmap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_bitmap
// Acknowledge bitmap: one bit per packet in a synchronous memory with a
// registered read, cleared by a sweep of one entry per cycle after reset.
// ----------------------------------------------------------------------------
module sas_bitmap (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sas_pkg::t_bm_req i_req,
    output logic             o_rd_bit,
    output logic             o_clr_busy
);
    import sas_pkg::*;

    logic             r_mem [MAX_PACKETS];
    logic             r_rd_bit;
    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_addr;

    // Advance the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {IDX_W{1'b1}}) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Write: clear sweep first, else mark one packet acked; read registered
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= 1'b1;
        end
        if (i_req.rd_en) begin
            r_rd_bit <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_bit   = r_rd_bit;
    assign o_clr_busy = r_clr_busy;

endmodule

### rtl/core/selective_ack_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_ack_scoreboard
// Sender-side scoreboard for selective-repeat transfer: tracks acked packets
// in a bitmap memory, moves the window base and scans for packets to send.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      word
//  i_in      in   valid/ready    command, cumulative_seq, selective_index
//  o_out     out  valid/ready    packet_index, send_valid, last_of_run,
//                                transfer_complete
//  i_cfg_*   in   write enable   register index, register data
//
//  An ack report loads one result word.
//  A scan reads each bitmap entry from the base (S_RD), then checks it
//  (S_CHK), as the memory read is registered; at the end S_RD passes to
//  S_END, which loads the last word.
//  After reset a clearing pass over every bitmap entry runs before the first word.
//  A full output register stalls the scan in place; commands are taken only
//  when the block is idle and the output register is empty.
// ----------------------------------------------------------------------------
module selective_ack_scoreboard (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sas_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sas_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sas_in_if.sink                         i_in,
    sas_out_if.source                      o_out
);
    import sas_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_CHK  = 2'd2;
    localparam logic [1:0] S_END  = 2'd3;

    localparam logic [CNT_W-1:0] TOTAL_MAX = CNT_W'(MAX_PACKETS);
    localparam logic [WIN_W-1:0] WIN_MAX   = WIN_W'(MAX_SCAN);
    localparam logic [WIN_W-1:0] WIN_MIN   = WIN_W'(1);

    // Configuration
    logic [CNT_W-1:0] r_total;
    logic [WIN_W-1:0] r_window;

    // Control state
    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_base, n_base;
    logic [CNT_W-1:0] r_i, n_i;
    logic [WIN_W-1:0] r_n, n_n;
    logic             r_pend, n_pend;
    logic [IDX_W-1:0] r_pend_idx, n_pend_idx;

    // Output register
    logic             r_out_valid, n_out_valid;
    logic [IDX_W-1:0] r_out_idx, n_out_idx;
    logic             r_out_send, n_out_send;
    logic             r_out_last, n_out_last;
    logic             r_out_done, n_out_done;

    logic             w_in_ready;
    logic             w_can_push;
    logic [CNT_W-1:0] w_total_eff;
    logic [WIN_W-1:0] w_win_eff;
    logic             w_done;
    logic [CNT_W-1:0] w_cum_sat;
    logic [CNT_W-1:0] w_sel_ext;
    logic             w_sel_ok;
    logic [CNT_W-1:0] w_base_new;
    logic             w_rd_bit;
    logic             w_clr_busy;
    t_bm_req          w_bm_req;

    sas_bitmap u_bitmap (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_bm_req),
        .o_rd_bit   (w_rd_bit),
        .o_clr_busy (w_clr_busy)
    );

    // Clamp the configuration into range
    assign w_total_eff = (r_total > TOTAL_MAX) ? TOTAL_MAX : r_total;
    assign w_win_eff   = (r_window == '0) ? WIN_MIN :
                         ((r_window > WIN_MAX) ? WIN_MAX : r_window);
    assign w_done      = (r_base >= w_total_eff);

    // Ack report update
    assign w_cum_sat  = (i_in.cumulative_seq > w_total_eff) ? w_total_eff
                                                            : i_in.cumulative_seq;
    assign w_sel_ext  = {1'b0, i_in.selective_index};
    assign w_sel_ok   = (w_sel_ext != i_in.cumulative_seq) && (w_sel_ext < w_total_eff);
    assign w_base_new = (w_cum_sat > r_base) ? w_cum_sat : r_base;

    assign w_can_push = !r_out_valid || o_out.ready;

    // Sequencer: ack, bitmap scan and result loading
    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_i         = r_i;
        n_n         = r_n;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_idx   = r_out_idx;
        n_out_send  = r_out_send;
        n_out_last  = r_out_last;
        n_out_done  = r_out_done;
        w_bm_req    = '0;
        w_in_ready  = 1'b0;

        case (r_state)
            S_IDLE: begin
                w_in_ready = !w_clr_busy && !r_out_valid;
                if (i_in.valid && w_in_ready) begin
                    if (i_in.command == CMD_ACK) begin
                        w_bm_req.wr_en   = w_sel_ok;
                        w_bm_req.wr_addr = i_in.selective_index;
                        n_base           = w_base_new;
                        n_out_valid      = 1'b1;
                        n_out_idx        = '0;
                        n_out_send       = 1'b0;
                        n_out_last       = 1'b1;
                        n_out_done       = (w_base_new >= w_total_eff);
                    end else begin
                        n_i     = r_base;
                        n_n     = '0;
                        n_pend  = 1'b0;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                if ((r_i >= w_total_eff) || (r_n == w_win_eff)) begin
                    n_state = S_END;
                end else begin
                    w_bm_req.rd_en   = 1'b1;
                    w_bm_req.rd_addr = r_i[IDX_W-1:0];
                    n_state          = S_CHK;
                end
            end
            S_CHK: begin
                if (w_rd_bit) begin
                    // already acked: skip
                    n_i     = r_i + 1'b1;
                    n_state = S_RD;
                end else if (!r_pend || w_can_push) begin
                    // hand the held index out, hold the new one
                    if (r_pend) begin
                        n_out_valid = 1'b1;
                        n_out_idx   = r_pend_idx;
                        n_out_send  = 1'b1;
                        n_out_last  = 1'b0;
                        n_out_done  = w_done;
                    end
                    n_pend     = 1'b1;
                    n_pend_idx = r_i[IDX_W-1:0];
                    n_n        = r_n + 1'b1;
                    n_i        = r_i + 1'b1;
                    n_state    = S_RD;
                end
            end
            S_END: begin
                if (w_can_push) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = r_pend ? r_pend_idx : '0;
                    n_out_send  = r_pend;
                    n_out_last  = 1'b1;
                    n_out_done  = w_done;
                    n_pend      = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_total     <= TOTAL_RST;
            r_window    <= WINDOW_RST;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TOTAL:  r_total  <= i_cfg_data;
                    REG_WINDOW: r_window <= i_cfg_data[WIN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_n        <= n_n;
        r_pend_idx <= n_pend_idx;
        r_out_idx  <= n_out_idx;
        r_out_send <= n_out_send;
        r_out_last <= n_out_last;
        r_out_done <= n_out_done;
    end

    assign i_in.ready              = w_in_ready;
    assign o_out.valid             = r_out_valid;
    assign o_out.packet_index      = r_out_idx;
    assign o_out.send_valid        = r_out_send;
    assign o_out.last_of_run       = r_out_last;
    assign o_out.transfer_complete = r_out_done;

    // No command is taken during the clearing pass
    a_no_cmd_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr_busy |-> !i_in.ready)
        else $error("command accepted during bitmap clear");

    // The window base never moves back
    a_base_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_base >= $past(r_base)))
        else $error("window base moved backward");

    // An index to send lies at or above the base
    a_send_above_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_send) |-> ({1'b0, r_out_idx} >= r_base))
        else $error("send index below window base");

    // An empty word always closes its run
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_send) |-> r_out_last)
        else $error("empty word without last flag");

endmodule

### bench/sas_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_result_checker
// Watches the command, result and register-write ports of the selective ack
// scoreboard. Keeps its own bitmap, window base and register copies, predicts
// the result words of every accepted command and compares each accepted
// result word, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module sas_result_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sas_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sas_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sas_in_if                              i_in,
    sas_out_if                             i_out,
    output int                             o_pending,
    output int                             o_errors,
    output int                             o_words_checked
);
    import sas_pkg::*;

    localparam int REPORT_CAP = 40;

    typedef struct packed {
        logic [IDX_W-1:0] packet_index;
        logic             send_valid;
        logic             last_of_run;
        logic             transfer_complete;
    } t_result_word;

    bit               acked [MAX_PACKETS];
    int unsigned      base_idx;
    logic [CNT_W-1:0] total_reg;
    logic [WIN_W-1:0] window_reg;
    t_result_word     expected_words [$];

    initial begin
        o_pending       = 0;
        o_errors        = 0;
        o_words_checked = 0;
    end

    // Transfer size as the block sees it: clipped to the bitmap depth
    function automatic int unsigned active_total();
        return (total_reg > MAX_PACKETS) ? MAX_PACKETS : int'(total_reg);
    endfunction

    // Ack report: fill below the cumulative number, mark the selective one
    function automatic void mark_acks(int unsigned cum, int unsigned sel);
        int unsigned  total;
        int unsigned  upto;
        t_result_word word;
        total = active_total();
        upto  = (cum > total) ? total : cum;
        for (int unsigned i = base_idx; i < upto; i++)
            acked[i] = 1'b1;
        if (sel != cum && sel < total)
            acked[sel] = 1'b1;
        if (upto > base_idx)
            base_idx = upto;
        word                   = '0;
        word.last_of_run       = 1'b1;
        word.transfer_complete = (base_idx >= total);
        expected_words.push_back(word);
    endfunction

    // Transmit scan: list unacked indices from the base, flag the last one
    function automatic void scan_unacked();
        int unsigned  total;
        int unsigned  win;
        int unsigned  found;
        logic         done;
        t_result_word word;
        total = active_total();
        if (window_reg == '0)
            win = 1;
        else if (window_reg > MAX_SCAN)
            win = MAX_SCAN;
        else
            win = window_reg;
        done  = (base_idx >= total);
        found = 0;
        word  = '0;
        for (int unsigned i = base_idx; i < total && found < win; i++) begin
            if (!acked[i]) begin
                if (found != 0)
                    expected_words.push_back(word);
                word.packet_index      = IDX_W'(i);
                word.send_valid        = 1'b1;
                word.last_of_run       = 1'b0;
                word.transfer_complete = done;
                found++;
            end
        end
        // an empty scan leaves word at zero: index 0, nothing to send
        word.last_of_run       = 1'b1;
        word.transfer_complete = done;
        expected_words.push_back(word);
    endfunction

    function automatic int field_mismatch(string name, int unsigned want,
                                          int unsigned got);
        if (want == got)
            return 0;
        if (o_errors < REPORT_CAP)
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_result_word want;
        t_result_word got;
        int           bad;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PACKETS; i++)
                acked[i] = 1'b0;
            base_idx   = 0;
            total_reg  = TOTAL_RST;
            window_reg = WINDOW_RST;
            expected_words.delete();
        end else begin
            // track register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TOTAL:  total_reg  = i_cfg_data;
                    REG_WINDOW: window_reg = i_cfg_data[WIN_W-1:0];
                    default: ;
                endcase
            end

            // compare the result word against the oldest prediction
            if (i_out.valid && i_out.ready) begin
                got.packet_index      = i_out.packet_index;
                got.send_valid        = i_out.send_valid;
                got.last_of_run       = i_out.last_of_run;
                got.transfer_complete = i_out.transfer_complete;
                if (expected_words.size() == 0) begin
                    if (o_errors < REPORT_CAP)
                        $display("%0t ns: unexpected word, expected none, actual %h",
                                 $time, got);
                    o_errors++;
                end else begin
                    want = expected_words.pop_front();
                    bad  = field_mismatch("packet_index", want.packet_index,
                                          got.packet_index)
                         + field_mismatch("send_valid", want.send_valid, got.send_valid)
                         + field_mismatch("last_of_run", want.last_of_run,
                                          got.last_of_run)
                         + field_mismatch("transfer_complete", want.transfer_complete,
                                          got.transfer_complete);
                    if (bad != 0)
                        o_errors++;
                    o_words_checked++;
                end
            end

            // predict the words of an accepted command
            if (i_in.valid && i_in.ready) begin
                if (i_in.command == CMD_ACK)
                    mark_acks(i_in.cumulative_seq, i_in.selective_index);
                else
                    scan_unacked();
            end
        end
        o_pending <= expected_words.size();
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the selective ack scoreboard with directed corner commands and a
// series of small randomized transfers (cumulative acks walking toward the
// total, selective acks ahead of it, scans in between, plus noise), under
// several register settings and idle patterns on both channels. Checking is
// done by sas_result_checker; this module makes stimulus and gives verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import sas_pkg::*;

    localparam int CLK_HALF   = 6;
    localparam int RST_CYCLES = 5;
    localparam int LIMIT      = 1_000_000;
    localparam int FIFO_DEPTH = 4;
    localparam int LONG_HOLD  = 400;
    localparam int PHASES     = 15;

    typedef struct packed {
        logic             command;
        logic [CNT_W-1:0] cum;
        logic [IDX_W-1:0] sel;
    } t_command;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    sas_in_if  in_ch ();
    sas_out_if out_ch ();

    int pending_words;
    int error_count;
    int words_checked;

    t_command    cmd_fifo [$];
    int          send_gap_pct   = 8;
    int          recv_stall_pct = 54;
    int          hold_requests  = 0;
    int unsigned cycle_count    = 0;
    int unsigned region_lo;
    int          n_acks     = 0;
    int          n_scans    = 0;
    int          n_settings = 0;

    selective_ack_scoreboard u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    sas_result_checker u_chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in            (in_ch),
        .i_out           (out_ch),
        .o_pending       (pending_words),
        .o_errors        (error_count),
        .o_words_checked (words_checked)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Command driver: offer the head of the queue, hold it until taken
    initial begin
        in_ch.valid           = 1'b0;
        in_ch.command         = CMD_ACK;
        in_ch.cumulative_seq  = '0;
        in_ch.selective_index = '0;
        forever begin
            @(posedge clk);
            if (!rst_n) begin
                in_ch.valid <= 1'b0;
            end else begin
                if (in_ch.valid && in_ch.ready)
                    void'(cmd_fifo.pop_front());
                if (in_ch.valid && !in_ch.ready) begin
                    // hold the offered word
                end else if (cmd_fifo.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    in_ch.valid           <= 1'b1;
                    in_ch.command         <= cmd_fifo[0].command;
                    in_ch.cumulative_seq  <= cmd_fifo[0].cum;
                    in_ch.selective_index <= cmd_fifo[0].sel;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls, plus long holds on request
    initial begin
        int holds_served;
        int hold_left;
        holds_served = 0;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (!rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog
    initial begin
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT) begin
                $display("timeout after %0d cycles, %0d words outstanding",
                         cycle_count, pending_words);
                $display("selective_ack_scoreboard: mismatch");
                $finish;
            end
        end
    end

    task automatic push_command(logic command, int unsigned cum, int unsigned sel);
        t_command word;
        while (cmd_fifo.size() >= FIFO_DEPTH)
            @(posedge clk);
        word.command = command;
        word.cum     = CNT_W'(cum);
        word.sel     = IDX_W'(sel);
        cmd_fifo.push_back(word);
        if (command == CMD_ACK)
            n_acks++;
        else
            n_scans++;
    endtask

    // Scan requests carry random, unused ack fields
    task automatic push_scan();
        push_command(CMD_SCAN, $urandom_range(8191), $urandom_range(4095));
    endtask

    // Wait until every command is taken and every word has come back
    task automatic drain();
        while (cmd_fifo.size() != 0 || in_ch.valid || pending_words != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(int unsigned total, int unsigned window);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_TOTAL;
        cfg_data <= CFG_DATA_W'(total);
        @(posedge clk);
        // upper data bits are don't-care for the window register
        cfg_idx  <= REG_WINDOW;
        cfg_data <= (CFG_DATA_W'($urandom) << WIN_W) | CFG_DATA_W'(window);
        @(posedge clk);
        cfg_we   <= 1'b0;
        n_settings++;
    endtask

    // One small transfer: acks walk toward the total, scans in between
    task automatic run_transfer(int unsigned span, int unsigned n_items,
                                bit hold_output, bit pause_midway);
        int unsigned lo;
        int unsigned hi;
        int unsigned cum;
        int unsigned sel;
        int unsigned back;
        int unsigned win;
        int unsigned r;
        lo = region_lo;
        hi = lo + span;
        case ($urandom_range(9))
            0:       win = 0;
            1:       win = 1;
            2:       win = $urandom_range(MAX_SCAN + 1, 127);
            3:       win = MAX_SCAN;
            default: win = $urandom_range(2, 16);
        endcase
        if (hold_output)
            win = MAX_SCAN;
        set_config(hi, win);
        if (hold_output)
            hold_requests++;
        cum = lo;
        for (int unsigned k = 0; k < n_items; k++) begin
            if (pause_midway && k == n_items / 2)
                drain();
            r = $urandom_range(99);
            if (r < 35) begin
                push_scan();
            end else if (r < 85) begin
                cum = cum + $urandom_range(0, 2);
                if (cum > hi)
                    cum = hi;
                sel = ($urandom_range(7) == 0) ? cum : cum + $urandom_range(1, 8);
                push_command(CMD_ACK, cum, sel & 12'hFFF);
            end else if ($urandom_range(9) == 0) begin
                push_command(CMD_ACK, $urandom_range(8191), $urandom_range(4095));
            end else begin
                back = (lo < 3) ? lo : 3;
                push_command(CMD_ACK, lo - $urandom_range(0, back) + $urandom_range(0, span + 5),
                             ($urandom_range(3) == 0) ? $urandom_range(4095)
                                                      : lo + $urandom_range(0, span + 5));
            end
        end
        // usually close the transfer and confirm nothing is left
        if ($urandom_range(3) != 0) begin
            push_command(CMD_ACK, hi, $urandom_range(4095));
            push_scan();
        end
        region_lo = hi;
    endtask

    initial begin
        int unsigned span;
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = REG_TOTAL;
        cfg_data = '0;
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: a single packet, index 0 to send
        push_scan();
        drain();

        // zero total: complete from the start
        set_config(0, 0);
        push_scan();
        push_command(CMD_ACK, 8191, 4095);
        push_command(CMD_ACK, 0, 0);

        // oversized total and window saturate
        set_config(8191, 127);
        push_scan();
        push_command(CMD_ACK, 0, 4095);
        push_command(CMD_ACK, 6, 6);
        push_command(CMD_ACK, 3, 10);
        push_scan();

        // window of one at the full depth
        set_config(4096, 1);
        push_scan();
        push_command(CMD_ACK, 7, 4095);
        push_scan();

        // total below the base
        set_config(3, MAX_SCAN);
        push_scan();
        push_command(CMD_ACK, 2, 1);

        set_config(4095, 2);
        push_command(CMD_ACK, 8, 8);
        push_scan();
        region_lo = 12;

        // randomized transfers under three idle patterns
        for (int p = 0; p < PHASES; p++) begin
            if (p == 5) begin
                send_gap_pct   = 54;
                recv_stall_pct = 8;
            end
            if (p == 10) begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            span = ($urandom_range(9) == 0) ? 1 : $urandom_range(3, 40);
            if (p == 11)
                span = 40;
            run_transfer(span, $urandom_range(28, 36), p == 11, p == 3);
        end

        // finish the whole transfer at the largest total
        set_config(8191, MAX_SCAN);
        push_scan();
        push_command(CMD_ACK, 8191, 4095);
        push_scan();

        drain();
        repeat (20) @(posedge clk);

        $display("covered %0d ack reports and %0d scans over %0d register settings",
                 n_acks, n_scans, n_settings);
        $display("%0d result words checked in %0d cycles", words_checked, cycle_count);
        if (error_count == 0 && pending_words == 0)
            $display("selective_ack_scoreboard: match");
        else
            $display("selective_ack_scoreboard: mismatch");
        $finish;
    end

endmodule
